### hw/rtl/cle_pkg.sv
// Shared types and codes for the circular list engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cle_pkg;

  localparam int CLE_CAPACITY = 32;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_AFTER = 3'd1,
    MODE_INS_BACK  = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_KEY   = 3'd4,
    MODE_DEL_BACK  = 3'd5,
    MODE_VIEW      = 3'd6,
    MODE_REVERSE   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_HEAD,
    S_WALK,
    S_LINK
  } state_t;

endpackage

### hw/rtl/cle_node_mem.sv
// Node pool storage: value and link arrays, one write port each,
// one shared synchronous read port. Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_node_mem import cle_pkg::*; #(
  parameter int CAPACITY = CLE_CAPACITY,
  parameter int AW = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_val,
  output logic [AW-1:0]     rd_link,
  input  logic              wr_val_en,
  input  logic [AW-1:0]     wr_val_addr,
  input  logic [DATA_W-1:0] wr_val_data,
  input  logic              wr_link_en,
  input  logic [AW-1:0]     wr_link_addr,
  input  logic [AW-1:0]     wr_link_data
);

  logic [DATA_W-1:0] val_mem [CAPACITY];
  logic [AW-1:0]     link_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_val_en) begin
      val_mem[wr_val_addr] <= wr_val_data;
    end
    if (wr_link_en) begin
      link_mem[wr_link_addr] <= wr_link_data;
    end
    rd_val  <= val_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

endmodule

### hw/rtl/circular_list_engine.sv
// Circular list engine: one node visited per cycle through a pool with a registered read port.
// Insert front/back steps through start, head and link states; key search, back delete
// and view walk one node per step after the head state; reverse walks twice, relinking
// and then reading out. One item is in flight at a time; a stalled result beat holds the walk.
// Reset (rst_n, synchronous) empties the list at once; the pool needs no clearing pass.
`timescale 1ns / 1ps

module circular_list_engine import cle_pkg::*; #(
  parameter int CAPACITY = CLE_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic signed [DATA_W-1:0] in_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;
  mode_t  op_r, op_nxt;
  logic [DATA_W-1:0] value_r, key_r;
  logic [AW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, head_r, head_nxt, lnk_r, lnk_nxt;
  logic mk_tail_r, mk_tail_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic empty_r, empty_nxt;
  logic [CAPACITY-1:0] used_r, used_nxt;

  logic out_valid_r;
  status_t out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic out_last_r;

  logic [AW-1:0] rd_addr, rd_link;
  logic [DATA_W-1:0] rd_val;
  logic wr_val_en, wr_link_en;
  logic [AW-1:0] wr_val_addr, wr_link_addr, wr_link_data;
  logic [DATA_W-1:0] wr_val_data;

  logic emit, emit_last;
  status_t emit_status;
  logic [DATA_W-1:0] emit_data;

  logic [AW-1:0] free_slot;
  logic full, can_emit, is_tail, key_hit, del_hit, is_ins, is_del;

  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  assign full     = (count_r == CW'(CAPACITY));
  assign can_emit = !out_valid_r || out_ready;
  assign is_tail  = (cur_r == tail_r);
  assign key_hit  = (rd_val == key_r);
  assign is_ins   = (op_r == MODE_INS_FRONT) || (op_r == MODE_INS_AFTER) ||
                    (op_r == MODE_INS_BACK);
  assign is_del   = (op_r == MODE_DEL_FRONT) || (op_r == MODE_DEL_KEY) ||
                    (op_r == MODE_DEL_BACK);
  assign del_hit  = (op_r == MODE_DEL_FRONT) ? 1'b1 :
                    (op_r == MODE_DEL_BACK) ? is_tail : key_hit;
  assign in_ready = (state_r == S_IDLE);

  cle_node_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
    .clk         (clk),
    .rd_addr     (rd_addr),
    .rd_val      (rd_val),
    .rd_link     (rd_link),
    .wr_val_en   (wr_val_en),
    .wr_val_addr (wr_val_addr),
    .wr_val_data (wr_val_data),
    .wr_link_en  (wr_link_en),
    .wr_link_addr(wr_link_addr),
    .wr_link_data(wr_link_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if ((is_ins && (full || empty_r)) || (!is_ins && empty_r)) begin
          if (can_emit) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (op_r == MODE_INS_FRONT || op_r == MODE_INS_BACK) state_nxt = S_LINK;
        else state_nxt = S_WALK;
      end
      S_LINK: begin
        if (can_emit) state_nxt = S_IDLE;
      end
      S_WALK: begin
        case (op_r)
          MODE_INS_AFTER: begin
            if (key_hit) state_nxt = S_LINK;
            else if (is_tail && can_emit) state_nxt = S_IDLE;
          end
          MODE_VIEW: begin
            if (is_tail && can_emit) state_nxt = S_IDLE;
          end
          MODE_REVERSE: begin
            if (is_tail) state_nxt = S_HEAD;
          end
          default: begin
            if ((del_hit || is_tail) && can_emit) state_nxt = S_IDLE;
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_nxt       = op_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    head_nxt     = head_r;
    lnk_nxt      = lnk_r;
    mk_tail_nxt  = mk_tail_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    empty_nxt    = empty_r;
    used_nxt     = used_r;
    rd_addr      = tail_r;
    wr_val_en    = 1'b0;
    wr_val_addr  = free_slot;
    wr_val_data  = value_r;
    wr_link_en   = 1'b0;
    wr_link_addr = free_slot;
    wr_link_data = rd_link;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_data    = '0;
    emit_last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) op_nxt = mode_t'(in_mode);
      end
      S_START: begin
        if (is_ins && full) begin
          emit        = can_emit;
          emit_status = ST_FULL;
        end else if (is_ins && empty_r) begin
          if (can_emit) begin
            emit               = 1'b1;
            wr_val_en          = 1'b1;
            wr_link_en         = 1'b1;
            wr_link_data       = free_slot;
            tail_nxt           = free_slot;
            empty_nxt          = 1'b0;
            count_nxt          = count_r + CW'(1);
            used_nxt[free_slot] = 1'b1;
          end
        end else if (!is_ins && empty_r) begin
          emit        = can_emit;
          emit_status = ST_EMPTY;
        end
      end
      S_HEAD: begin
        if (op_r == MODE_INS_FRONT || op_r == MODE_INS_BACK) begin
          wr_val_en   = 1'b1;
          wr_link_en  = 1'b1;
          lnk_nxt     = tail_r;
          mk_tail_nxt = (op_r == MODE_INS_BACK);
        end else begin
          cur_nxt  = rd_link;
          prev_nxt = tail_r;
          head_nxt = rd_link;
          rd_addr  = rd_link;
        end
      end
      S_LINK: begin
        if (can_emit) begin
          emit                = 1'b1;
          wr_link_en          = 1'b1;
          wr_link_addr        = lnk_r;
          wr_link_data        = free_slot;
          count_nxt           = count_r + CW'(1);
          used_nxt[free_slot] = 1'b1;
          if (mk_tail_r) tail_nxt = free_slot;
        end
      end
      S_WALK: begin
        rd_addr = cur_r;
        if (op_r == MODE_INS_AFTER) begin
          if (key_hit) begin
            wr_val_en   = 1'b1;
            wr_link_en  = 1'b1;
            lnk_nxt     = cur_r;
            mk_tail_nxt = is_tail;
          end else if (is_tail) begin
            emit        = can_emit;
            emit_status = ST_NOTFOUND;
          end else begin
            cur_nxt  = rd_link;
            prev_nxt = cur_r;
            rd_addr  = rd_link;
          end
        end else if (is_del) begin
          if (del_hit) begin
            if (can_emit) begin
              emit            = 1'b1;
              emit_data       = rd_val;
              used_nxt[cur_r] = 1'b0;
              count_nxt       = count_r - CW'(1);
              if (count_r == CW'(1)) begin
                empty_nxt = 1'b1;
                tail_nxt  = '0;
              end else begin
                wr_link_en   = 1'b1;
                wr_link_addr = prev_r;
                if (is_tail) tail_nxt = prev_r;
              end
            end
          end else if (is_tail) begin
            emit        = can_emit;
            emit_status = ST_NOTFOUND;
          end else begin
            cur_nxt  = rd_link;
            prev_nxt = cur_r;
            rd_addr  = rd_link;
          end
        end else if (op_r == MODE_VIEW) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_data = rd_val;
            emit_last = is_tail;
            if (!is_tail) begin
              cur_nxt  = rd_link;
              prev_nxt = cur_r;
              rd_addr  = rd_link;
            end
          end
        end else begin
          // reverse: point each node back at its predecessor, then read out
          wr_link_en   = 1'b1;
          wr_link_addr = cur_r;
          wr_link_data = prev_r;
          if (is_tail) begin
            tail_nxt = head_r;
            rd_addr  = head_r;
            op_nxt   = MODE_VIEW;
          end else begin
            cur_nxt  = rd_link;
            prev_nxt = cur_r;
            rd_addr  = rd_link;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tail_r      <= '0;
      count_r     <= '0;
      empty_r     <= 1'b1;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      op_r        <= MODE_VIEW;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      empty_r <= empty_nxt;
      used_r  <= used_nxt;
      op_r    <= op_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      value_r <= in_value;
      key_r   <= in_key;
    end
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    head_r    <= head_nxt;
    lnk_r     <= lnk_nxt;
    mk_tail_r <= mk_tail_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_data_r   <= emit_data;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = $signed(out_data_r);
  assign out_last   = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("node count above capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r == (count_r == '0))
    else $error("empty flag disagrees with node count");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(count_r))
    else $error("slot map disagrees with node count");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_START)
    else $error("accepted beat did not start an operation");

endmodule

### sim/tb_top.sv
// Testbench for circular_list_engine: directed and random list operations checked
// beat by beat against a behavioral list predictor. Depends on cle_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top import cle_pkg::*; ();

  localparam int CAP = CLE_CAPACITY;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_mode;
  logic signed [31:0] in_value;
  logic signed [31:0] in_key;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic signed [31:0] out_data;
  logic out_last;

  circular_list_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_value(in_value), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_data(out_data), .out_last(out_last)
  );

  typedef struct packed {
    status_t st;
    logic [31:0] data;
    logic last;
  } beat_t;

  // Predicted list contents, head first.
  logic [31:0] list_vals[$];
  beat_t expected_beats[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_off = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic push_beat(input status_t st, input logic [31:0] d, input logic l);
    beat_t b;
    b.st = st;
    b.data = d;
    b.last = l;
    expected_beats.push_back(b);
  endtask

  function automatic int find_key(input logic [31:0] k);
    foreach (list_vals[i]) if (list_vals[i] == k) return i;
    return -1;
  endfunction

  task automatic predict_list_op(input mode_t m, input logic [31:0] v, input logic [31:0] k);
    int idx;
    int n;
    n = list_vals.size();
    case (m)
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AFTER: begin
        if (n >= CAP) push_beat(ST_FULL, 0, 1);
        else if (m == MODE_INS_FRONT) begin
          list_vals.push_front(v);
          push_beat(ST_OK, 0, 1);
        end else if (m == MODE_INS_BACK || n == 0) begin
          list_vals.push_back(v);
          push_beat(ST_OK, 0, 1);
        end else begin
          idx = find_key(k);
          if (idx < 0) push_beat(ST_NOTFOUND, 0, 1);
          else begin
            list_vals.insert(idx + 1, v);
            push_beat(ST_OK, 0, 1);
          end
        end
      end
      MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_KEY: begin
        if (n == 0) push_beat(ST_EMPTY, 0, 1);
        else begin
          idx = (m == MODE_DEL_FRONT) ? 0 : (m == MODE_DEL_BACK) ? n - 1 : find_key(k);
          if (idx < 0) push_beat(ST_NOTFOUND, 0, 1);
          else begin
            push_beat(ST_OK, list_vals[idx], 1);
            list_vals.delete(idx);
          end
        end
      end
      default: begin
        if (n == 0) push_beat(ST_EMPTY, 0, 1);
        else begin
          if (m == MODE_REVERSE)
            for (int i = 0; i < n / 2; i++) begin
              logic [31:0] t;
              t = list_vals[i];
              list_vals[i] = list_vals[n - 1 - i];
              list_vals[n - 1 - i] = t;
            end
          foreach (list_vals[i]) push_beat(ST_OK, list_vals[i], i == n - 1);
        end
      end
    endcase
  endtask

  // Offer one beat and hold it until accepted; drop valid only while idling.
  task automatic send_op(input mode_t m, input logic [31:0] v, input logic [31:0] k);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_value <= v;
    in_key <= k;
    do @(posedge clk); while (!in_ready);
    predict_list_op(m, v, k);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Receiver: random stall, plus a counted long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beat_t e;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_data, 0);
      end else begin
        e = expected_beats.pop_front();
        if (out_status != e.st) report_mismatch("status", out_status, e.st);
        if (out_data != e.data) report_mismatch("data", out_data, e.data);
        if (out_last != e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom_range(7);
    if (list_vals.size() > 0 && $urandom_range(3) == 0)
      r = list_vals[$urandom_range(list_vals.size() - 1)];
    else if ($urandom_range(3) == 0) r = $urandom;
    return r;
  endfunction

  task automatic test_directed();
    send_op(MODE_DEL_FRONT, 0, 0);
    send_op(MODE_DEL_KEY, 0, 0);
    send_op(MODE_DEL_BACK, 0, 0);
    send_op(MODE_VIEW, 0, 0);
    send_op(MODE_REVERSE, 0, 0);
    send_op(MODE_INS_AFTER, 32'h8000_0000, 32'h1234);
    send_op(MODE_INS_FRONT, 32'h7fff_ffff, 0);
    send_op(MODE_INS_BACK, 32'hffff_ffff, 0);
    send_op(MODE_INS_AFTER, 32'h0, 32'hffff_ffff);
    send_op(MODE_INS_AFTER, 32'h5, 32'h7fff_ffff);
    send_op(MODE_INS_BACK, 32'h5, 0);
    send_op(MODE_INS_AFTER, 32'h9, 32'h5);
    send_op(MODE_INS_AFTER, 32'h1, 32'h4444);
    send_op(MODE_VIEW, 0, 0);
    send_op(MODE_REVERSE, 0, 0);
    send_op(MODE_DEL_KEY, 0, 32'h5);
    send_op(MODE_DEL_KEY, 0, 32'h4444);
    send_op(MODE_DEL_FRONT, 0, 0);
    send_op(MODE_DEL_BACK, 0, 0);
    send_op(MODE_VIEW, 0, 0);
    wait_drain();
  endtask

  // Fill past capacity with the receiver held off, then drain the pool.
  task automatic test_full_pool();
    hold_req++;
    for (int i = 0; i < CAP + 2; i++) send_op(MODE_INS_BACK, $urandom, 0);
    send_op(MODE_INS_AFTER, 1, list_vals[0]);
    send_op(MODE_INS_FRONT, 1, 0);
    send_op(MODE_REVERSE, 0, 0);
    send_op(MODE_INS_AFTER, 2, list_vals[CAP - 1]);
    wait_drain();
    while (list_vals.size() > 0)
      send_op($urandom_range(1) ? MODE_DEL_BACK : MODE_DEL_FRONT, 0, 0);
    wait_drain();
  endtask

  task automatic test_random(input int count, input int sidle, input int rstall);
    mode_t m;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < count; i++) begin
      m = mode_t'(3'($urandom_range(7)));
      if (list_vals.size() < 4 && $urandom_range(1)) m = MODE_INS_BACK;
      send_op(m, pick_value(), pick_value());
    end
    wait_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_value = '0;
    in_key = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_pool();
    test_random(65, 0, 0);
    test_random(65, 48, 0);
    test_random(65, 0, 48);
    test_random(65, 9, 9);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
